// File: src/ros_pkg.sv
// Package for the region overlay splitter: request and result structs, op and
// register codes, type-code lookup functions. No dependencies.
package ros_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  localparam logic       REG_OUT_CAPACITY   = 1'b0;
  localparam logic       REG_REGISTRY_USED  = 1'b1;

  localparam logic [2:0] CLASS_FREE     = 3'd0;
  localparam logic [2:0] CLASS_BOOT     = 3'd1;
  localparam logic [2:0] CLASS_RESERVED = 3'd3;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [31:0] start_page;
    logic [31:0] page_total;
    logic [3:0]  overlay_kind;
    logic [2:0]  region_class;
  } in_req_t;

  typedef struct packed {
    logic        has_entry;
    logic [4:0]  mem_type;
    logic [31:0] first_page;
    logic [31:0] span_pages;
    logic        last;
    logic [15:0] entries_so_far;
  } out_rsp_t;

  // Overlay slot as stored in the overlay memory.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] count;
    logic [31:0] base;
  } ovl_word_t;

  // Descriptor as stored in the result memory.
  typedef struct packed {
    logic [4:0]  mem_type;
    logic [31:0] base;
    logic [31:0] pages;
  } desc_t;

  function automatic logic [4:0] kind_code(input logic [3:0] k);
    logic [4:0] r;
    case (k)
      4'd0: r = 5'd9;
      4'd1: r = 5'd10;
      4'd2: r = 5'd11;
      4'd3: r = 5'd19;
      4'd4: r = 5'd21;
      4'd5: r = 5'd17;
      4'd6: r = 5'd20;
      4'd7: r = 5'd6;
      4'd8: r = 5'd5;
      default: r = 5'd2;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] class_code(input logic [2:0] c);
    logic [4:0] r;
    case (c)
      CLASS_FREE: r = 5'd2;
      CLASS_BOOT: r = 5'd5;
      default:    r = 5'd6;
    endcase
    return r;
  endfunction

endpackage

// File: src/ros_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module ros_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/region_overlay_splitter_unit.sv
// Top level of the region overlay splitter: control sequencer, pending entry,
// overlay memory and result memory (ros_ram). Depends on ros_pkg, ros_ram.
//
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    in_req  (in_req_t)
//  out       out  out_valid/out_ready  out_rsp (out_rsp_t)
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// A load or flush request is handled in the idle state. A region request
// runs a loop: a scan reads one overlay slot per cycle (registered read,
// none when no slot is in use); the leading gap, if any, and the overlap
// found are then placed, or the rest of the region if none is found; each
// emitted descriptor then drains via a result memory read and load. Reset is
// synchronous and clears control state and the pending entry; memories are
// not cleared. A stalled output holds the sequencer in its drain step and
// keeps in_ready low.
module region_overlay_splitter_unit
  import ros_pkg::*;
#(
  parameter int OVERLAY_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output out_rsp_t   out_rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW        = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 1;
  localparam int RES_DEPTH = 2 * OVERLAY_ENTRIES + 1;
  localparam int RAW       = $clog2(RES_DEPTH);
  localparam int RW        = $clog2(RES_DEPTH + 1);
  localparam logic [4:0] SLOTS = 5'(OVERLAY_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_RD    = 5'b01000,
    S_LD    = 5'b10000
  } state_t;

  state_t      state;
  logic [15:0] out_capacity;
  logic [4:0]  registry_used;

  // Current region walk.
  logic [31:0] cursor;
  logic [31:0] end_page;
  logic [4:0]  coarse;

  // Overlay scan and best-overlap tracking.
  logic [4:0]  scan_idx;
  logic        rd_vld;
  logic [31:0] best_start;
  logic [31:0] best_end;
  logic [4:0]  best_type;
  logic        found;

  // Pending entry.
  logic        pend_valid;
  logic [4:0]  pend_type;
  logic [31:0] pend_base;
  logic [31:0] pend_pages;
  logic [15:0] entry_count;

  // Result buffer bookkeeping.
  logic [RW-1:0] res_n;
  logic [RW-1:0] drain_idx;

  ovl_word_t ovl_rdata;
  desc_t     res_rdata;

  logic        in_fire;
  logic        ovl_we;
  logic [4:0]  used_lim;
  logic        issue;
  logic [31:0] req_end;
  logic        req_skip;

  logic [31:0] rb, re, os, oe;
  logic        better;

  logic [4:0]  p_type;
  logic [31:0] p_base;
  logic [31:0] p_pages;
  logic        p_finish;
  logic        p_gap;
  logic        add_ok;
  logic        merge;
  logic        emit;
  logic [RW-1:0] res_n_next;
  logic        out_free;
  logic        out_load;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  // Load the output register on a flush or on a drained descriptor.
  assign out_load = (in_fire && (in_req.op == OP_FLUSH)) || ((state == S_LD) && out_free);

  assign ovl_we   = in_fire && (in_req.op == OP_LOAD) && ({1'b0, in_req.entry_index} < SLOTS);
  assign used_lim = (registry_used > SLOTS) ? SLOTS : registry_used;
  assign issue    = scan_idx < used_lim;
  assign req_end  = in_req.start_page + in_req.page_total;
  assign req_skip = (in_req.region_class == CLASS_RESERVED) || (in_req.page_total == 32'd0) ||
                    (req_end <= in_req.start_page);

  // Intersection of the slot read back with the rest of the region.
  always_comb begin
    rb     = ovl_rdata.base;
    re     = ovl_rdata.base + ovl_rdata.count;
    os     = (rb > cursor) ? rb : cursor;
    oe     = (re < end_page) ? re : end_page;
    better = rd_vld && (os < oe) && (os < best_start);
  end

  // Choose the next piece: trailing gap, leading gap, or the overlap.
  always_comb begin
    p_gap = 1'b0;
    if (!found) begin
      p_type   = coarse;
      p_base   = cursor;
      p_pages  = end_page - cursor;
      p_finish = 1'b1;
    end else if (best_start != cursor) begin
      p_type   = coarse;
      p_base   = cursor;
      p_pages  = best_start - cursor;
      p_finish = 1'b0;
      p_gap    = 1'b1;
    end else begin
      p_type   = best_type;
      p_base   = best_start;
      p_pages  = best_end - best_start;
      p_finish = (best_end == end_page);
    end
    add_ok     = (p_pages != 32'd0) && (entry_count < out_capacity);
    merge      = pend_valid && (pend_type == p_type) && ((pend_base + pend_pages) == p_base);
    emit       = (state == S_PLACE) && add_ok && !merge && pend_valid;
    res_n_next = emit ? res_n + RW'(1) : res_n;
  end

  ros_ram #(
    .DEPTH (OVERLAY_ENTRIES),
    .WIDTH ($bits(ovl_word_t))
  ) u_ovl_ram (
    .clk   (clk),
    .we    (ovl_we),
    .waddr (IW'(in_req.entry_index)),
    .wdata ({in_req.overlay_kind, in_req.page_total, in_req.start_page}),
    .raddr (scan_idx[IW-1:0]),
    .rdata (ovl_rdata)
  );

  // Written only while placing, read data used only while draining: no overlap.
  ros_ram #(
    .DEPTH (RES_DEPTH),
    .WIDTH ($bits(desc_t))
  ) u_res_ram (
    .clk   (clk),
    .we    (emit),
    .waddr (res_n[RAW-1:0]),
    .wdata ({pend_type, pend_base, pend_pages}),
    .raddr (drain_idx[RAW-1:0]),
    .rdata (res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_capacity  <= CAPACITY_RESET;
      registry_used <= 5'd0;
      pend_valid    <= 1'b0;
      pend_type     <= 5'd0;
      pend_base     <= 32'd0;
      pend_pages    <= 32'd0;
      entry_count   <= 16'd0;
      out_valid     <= 1'b0;
      rd_vld        <= 1'b0;
      scan_idx      <= 5'd0;
      found         <= 1'b0;
      res_n         <= '0;
      drain_idx     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OUT_CAPACITY:  out_capacity  <= cfg_data;
          REG_REGISTRY_USED: registry_used <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && in_req.op == OP_FLUSH) begin
            // Flush: report pending entry and count, then start a new list.
            out_rsp.has_entry      <= pend_valid;
            out_rsp.mem_type       <= pend_valid ? pend_type : 5'd0;
            out_rsp.first_page     <= pend_valid ? pend_base : 32'd0;
            out_rsp.span_pages     <= pend_valid ? pend_pages : 32'd0;
            out_rsp.last           <= 1'b1;
            out_rsp.entries_so_far <= entry_count;
            pend_valid  <= 1'b0;
            pend_type   <= 5'd0;
            pend_base   <= 32'd0;
            pend_pages  <= 32'd0;
            entry_count <= 16'd0;
          end else if (in_fire && in_req.op == OP_PROCESS && !req_skip) begin
            cursor     <= in_req.start_page;
            end_page   <= req_end;
            coarse     <= class_code(in_req.region_class);
            res_n      <= '0;
            scan_idx   <= 5'd0;
            rd_vld     <= 1'b0;
            best_start <= req_end;
            best_end   <= req_end;
            found      <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Advance one slot per cycle; evaluate the slot read last cycle.
          if (issue) begin
            scan_idx <= scan_idx + 5'd1;
          end
          rd_vld <= issue;
          if (better) begin
            best_start <= os;
            best_end   <= oe;
            best_type  <= kind_code(ovl_rdata.kind);
            found      <= 1'b1;
          end
          if (!issue && !rd_vld) begin
            state <= S_PLACE;
          end
        end

        S_PLACE: begin
          if (add_ok) begin
            if (merge) begin
              pend_pages <= pend_pages + p_pages;
            end else begin
              pend_valid  <= 1'b1;
              pend_type   <= p_type;
              pend_base   <= p_base;
              pend_pages  <= p_pages;
              entry_count <= entry_count + 16'd1;
            end
          end
          res_n <= res_n_next;
          if (p_gap) begin
            cursor <= best_start;
          end else if (p_finish) begin
            drain_idx <= '0;
            state     <= (res_n_next == '0) ? S_IDLE : S_RD;
          end else begin
            // Overlap placed, rescan from its end.
            cursor     <= best_end;
            scan_idx   <= 5'd0;
            rd_vld     <= 1'b0;
            best_start <= end_page;
            best_end   <= end_page;
            found      <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_RD: begin
          state <= S_LD;
        end

        S_LD: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_rsp.has_entry      <= 1'b1;
            out_rsp.mem_type       <= res_rdata.mem_type;
            out_rsp.first_page     <= res_rdata.base;
            out_rsp.span_pages     <= res_rdata.pages;
            out_rsp.last           <= (drain_idx == res_n - RW'(1));
            out_rsp.entries_so_far <= entry_count;
            drain_idx              <= drain_idx + RW'(1);
            state <= (drain_idx == res_n - RW'(1)) ? S_IDLE : S_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/ros_checker.sv
// Port-level checks for region_overlay_splitter_unit and the bind that attaches
// them. Depends on ros_pkg.
module ros_checker
  import ros_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.has_entry |-> out_rsp.last && out_rsp.mem_type == 5'd0 &&
      out_rsp.first_page == 32'd0 && out_rsp.span_pages == 32'd0)
    else $error("empty result carries data");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.has_entry |-> out_rsp.span_pages != 32'd0)
    else $error("descriptor with zero pages");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("request taken while result stalled");

endmodule

bind region_overlay_splitter_unit ros_checker u_ros_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

// File: tb/tb_top.sv
// Testbench for region_overlay_splitter_unit: directed and random requests,
// a cycle-free predictor of the descriptor stream and a result checker.
// Depends on ros_pkg and the unit itself.
module tb_top;
  import ros_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 1500;   // idle wait that covers a region walk with nothing emitted

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Overlay kinds as carried in the request.
  localparam logic [3:0] KIND_KERNEL   = 4'd0;
  localparam logic [3:0] KIND_HAL      = 4'd1;
  localparam logic [3:0] KIND_BOOTDRV  = 4'd2;
  localparam logic [3:0] KIND_REGISTRY = 4'd3;
  localparam logic [3:0] KIND_NLS      = 4'd4;
  localparam logic [3:0] KIND_PCR      = 4'd5;
  localparam logic [3:0] KIND_MEMDATA  = 4'd6;
  localparam logic [3:0] KIND_FWPERM   = 4'd7;
  localparam logic [3:0] KIND_FWTEMP   = 4'd8;
  localparam logic [3:0] KIND_OTHER    = 4'd9;

  localparam logic [2:0] CLASS_FIRMWARE = 3'd2;
  localparam logic [2:0] CLASS_OTHER    = 3'd4;

  // Descriptor memory types.
  localparam logic [4:0] MT_FREE     = 5'd2;
  localparam logic [4:0] MT_RECLAIM  = 5'd5;
  localparam logic [4:0] MT_FIRMWARE = 5'd6;
  localparam logic [4:0] MT_KERNEL   = 5'd9;
  localparam logic [4:0] MT_HAL      = 5'd10;
  localparam logic [4:0] MT_BOOTDRV  = 5'd11;
  localparam logic [4:0] MT_PCR      = 5'd17;
  localparam logic [4:0] MT_REGISTRY = 5'd19;
  localparam logic [4:0] MT_MEMDATA  = 5'd20;
  localparam logic [4:0] MT_NLS      = 5'd21;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_rsp_t    out_rsp;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  region_overlay_splitter_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the overlay table, the pending descriptor and registers.
  logic [31:0] ovl_first [SLOTS];
  logic [31:0] ovl_len [SLOTS];
  logic [3:0]  ovl_kind [SLOTS];
  bit          pend_on = 1'b0;
  logic [4:0]  pend_type = '0;
  logic [31:0] pend_first = '0;
  logic [31:0] pend_len = '0;
  logic [15:0] desc_count = '0;
  logic [15:0] capacity = CAPACITY_RESET;
  logic [4:0]  slots_used = '0;

  out_rsp_t descs_expected [$];
  out_rsp_t item_descs [$];
  int       errors = 0;
  bit       quiet = 1'b0;
  int       stall_left = 0;
  logic [31:0] next_start = '0;   // end of the last region, for contiguous runs

  function automatic logic [4:0] overlay_type(logic [3:0] k);
    case (k)
      KIND_KERNEL:   return MT_KERNEL;
      KIND_HAL:      return MT_HAL;
      KIND_BOOTDRV:  return MT_BOOTDRV;
      KIND_REGISTRY: return MT_REGISTRY;
      KIND_NLS:      return MT_NLS;
      KIND_PCR:      return MT_PCR;
      KIND_MEMDATA:  return MT_MEMDATA;
      KIND_FWPERM:   return MT_FIRMWARE;
      KIND_FWTEMP:   return MT_RECLAIM;
      default:       return MT_FREE;
    endcase
  endfunction

  function automatic logic [4:0] region_type(logic [2:0] c);
    case (c)
      CLASS_FREE: return MT_FREE;
      CLASS_BOOT: return MT_RECLAIM;
      default:    return MT_FIRMWARE;
    endcase
  endfunction

  // Merge a piece into the pending descriptor, or retire that one and open a new one.
  task automatic place_piece(logic [4:0] t, logic [31:0] b, logic [31:0] n);
    out_rsp_t r;
    if (n == 0 || desc_count >= capacity) return;
    if (pend_on && pend_type == t && pend_first + pend_len == b) begin
      pend_len = pend_len + n;
      return;
    end
    if (pend_on) begin
      r = '0;
      r.has_entry = 1'b1;
      r.mem_type = pend_type;
      r.first_page = pend_first;
      r.span_pages = pend_len;
      item_descs.push_back(r);
    end
    pend_on = 1'b1;
    pend_type = t;
    pend_first = b;
    pend_len = n;
    desc_count = desc_count + 16'd1;
  endtask

  task automatic predict_descs(in_req_t q);
    out_rsp_t r;
    logic [31:0] cur, stop, bs, be, rb, re, os, oe;
    logic [4:0] bt, coarse;
    bit hit;
    int used;
    item_descs.delete();
    case (q.op)
      OP_LOAD: begin
        ovl_first[q.entry_index] = q.start_page;
        ovl_len[q.entry_index] = q.page_total;
        ovl_kind[q.entry_index] = q.overlay_kind;
      end
      OP_FLUSH: begin
        r = '0;
        r.has_entry = pend_on;
        if (pend_on) begin
          r.mem_type = pend_type;
          r.first_page = pend_first;
          r.span_pages = pend_len;
        end
        r.last = 1'b1;
        r.entries_so_far = desc_count;
        descs_expected.push_back(r);
        pend_on = 1'b0;
        pend_type = '0;
        pend_first = '0;
        pend_len = '0;
        desc_count = '0;
      end
      OP_PROCESS: begin
        if (q.region_class != CLASS_RESERVED && q.page_total != 0) begin
          coarse = region_type(q.region_class);
          cur = q.start_page;
          stop = q.start_page + q.page_total;
          used = (slots_used < SLOTS) ? slots_used : SLOTS;
          while (cur < stop) begin
            bs = stop;
            be = stop;
            bt = '0;
            hit = 1'b0;
            for (int i = 0; i < used; i++) begin
              rb = ovl_first[i];
              re = rb + ovl_len[i];
              os = (rb > cur) ? rb : cur;
              oe = (re < stop) ? re : stop;
              // earliest overlap start wins; strict compare keeps the lower slot
              if (os < oe && os < bs) begin
                bs = os;
                be = oe;
                bt = overlay_type(ovl_kind[i]);
                hit = 1'b1;
              end
            end
            if (!hit) begin
              place_piece(coarse, cur, stop - cur);
              break;
            end
            if (bs > cur) place_piece(coarse, cur, bs - cur);
            place_piece(bt, bs, be - bs);
            cur = be;
          end
          foreach (item_descs[k]) begin
            item_descs[k].last = (k == item_descs.size() - 1);
            item_descs[k].entries_so_far = desc_count;
            descs_expected.push_back(item_descs[k]);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drive one request; valid stays high between requests but for random gaps when not quiet.
  task automatic send_req(in_req_t q);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_descs(q);
  endtask

  // Drop valid, then hold until every expected descriptor is back.
  task automatic drain_out;
    in_valid <= 1'b0;
    @(posedge clk);
    while (descs_expected.size() > 0) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    drain_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OUT_CAPACITY) capacity = val;
    else slots_used = val[4:0];
  endtask

  function automatic in_req_t mk_req(logic [1:0] op, logic [3:0] slot, logic [31:0] s,
                                     logic [31:0] n, logic [3:0] k, logic [2:0] c);
    in_req_t q;
    q.op = op;
    q.entry_index = slot;
    q.start_page = s;
    q.page_total = n;
    q.overlay_kind = k;
    q.region_class = c;
    return q;
  endfunction

  function automatic in_req_t random_req();
    int p;
    in_req_t q;
    p = $urandom_range(0, 99);
    q = mk_req(OP_PROCESS, 4'($urandom_range(0, 15)), $urandom, $urandom,
               4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
    if (p < 7) begin
      // reload a slot; mostly small ranges so they land on regions
      q.op = OP_LOAD;
      if (p > 0) begin
        q.start_page = $urandom_range(0, 2000);
        q.page_total = $urandom_range(0, 200);
      end
    end else if (p < 15) begin
      q.op = OP_FLUSH;
    end else if (p < 17) begin
      q.op = OP_UNUSED;
    end else if (p > 20) begin
      // well-formed region, often contiguous with the last one for merging
      q.start_page = ($urandom_range(0, 1) == 0) ? next_start : $urandom_range(0, 2000);
      q.page_total = $urandom_range(1, 400);
      next_start = q.start_page + q.page_total;
    end
    return q;
  endfunction

  // Receiver: random stall bursts, none once quiet.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result against the oldest expected descriptor.
  always @(posedge clk) begin
    out_rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (descs_expected.size() == 0) begin
        $error("unexpected result %p", out_rsp);
        errors++;
      end else begin
        e = descs_expected.pop_front();
        check_field("has_entry", 32'(e.has_entry), 32'(out_rsp.has_entry));
        check_field("mem_type", 32'(e.mem_type), 32'(out_rsp.mem_type));
        check_field("first_page", e.first_page, out_rsp.first_page);
        check_field("span_pages", e.span_pages, out_rsp.span_pages);
        check_field("last", 32'(e.last), 32'(out_rsp.last));
        check_field("entries_so_far", 32'(e.entries_so_far), 32'(out_rsp.entries_so_far));
      end
    end
  end

  // Empty scan, flush of an empty list, ignored ops, skipped regions.
  task automatic test_empty_table;
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd100, 32'd50, KIND_KERNEL, CLASS_FREE));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd150, 32'd10, KIND_KERNEL, CLASS_FREE));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
    send_req(mk_req(OP_UNUSED, 4'hF, '1, '1, 4'hF, 3'h7));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'd20, KIND_KERNEL, CLASS_RESERVED));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_BOOT));
  endtask

  // Fill every slot, then split regions against the whole table.
  task automatic test_overlay_split;
    for (int i = 0; i < SLOTS; i++)
      send_req(mk_req(OP_LOAD, 4'(i), 32'(32'd100 * i + 10),
                      (i == 5) ? 32'd0 : 32'(32'd40 + i), i[3:0], CLASS_FREE));
    set_reg(REG_REGISTRY_USED, 16'd31);
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'd1700, KIND_KERNEL, CLASS_BOOT));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd1700, 32'd20, KIND_KERNEL, CLASS_BOOT));
    // wrapping region yields no pieces
    send_req(mk_req(OP_PROCESS, 4'd0, 32'hFFFF_FF00, 32'h200, KIND_KERNEL, CLASS_OTHER));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'hFFFF_FFFF, KIND_KERNEL, 3'd7));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
    // overlapping slots: earliest start wins, ties to the lower slot
    send_req(mk_req(OP_LOAD, 4'd0, 32'd500, 32'd30, KIND_FWPERM, CLASS_FREE));
    send_req(mk_req(OP_LOAD, 4'd1, 32'd500, 32'd60, KIND_FWTEMP, CLASS_FREE));
    send_req(mk_req(OP_LOAD, 4'd2, 32'hFFFF_FFF0, 32'h20, KIND_OTHER, CLASS_FREE));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd480, 32'd100, KIND_KERNEL, CLASS_FIRMWARE));
    send_req(mk_req(OP_PROCESS, 4'd0, 32'hFFFF_FF00, 32'hFF, KIND_KERNEL, 3'd5));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
  endtask

  // Capacity extremes: one entry, a few, then the maximum restored.
  task automatic test_capacity;
    set_reg(REG_OUT_CAPACITY, 16'd1);
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'd1700, KIND_KERNEL, CLASS_FREE));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
    set_reg(REG_OUT_CAPACITY, 16'd3);
    send_req(mk_req(OP_PROCESS, 4'd0, 32'd0, 32'd1700, KIND_KERNEL, CLASS_BOOT));
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
    set_reg(REG_OUT_CAPACITY, 16'hFFFF);
  endtask

  // Random phases across register settings; pause once for a full drain.
  task automatic test_random;
    logic [15:0] caps [4];
    logic [15:0] useds [4];
    caps = '{16'd256, 16'd2, 16'hFFFF, 16'd7};
    useds = '{16'd16, 16'd0, 16'd4, 16'd31};
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_OUT_CAPACITY, (ph == 3) ? 16'($urandom_range(1, 65535)) : caps[ph]);
      set_reg(REG_REGISTRY_USED, (ph == 3) ? 16'($urandom_range(0, 31)) : useds[ph]);
      for (int n = 0; n < 90; n++) begin
        if (ph == 1 && n == 45) drain_out();
        send_req(random_req());
      end
    end
  endtask

  // Last stretch with no idling on either side.
  task automatic test_quiet_tail;
    set_reg(REG_OUT_CAPACITY, 16'd256);
    set_reg(REG_REGISTRY_USED, 16'd16);
    quiet = 1'b1;
    for (int n = 0; n < 40; n++) send_req(random_req());
    send_req(mk_req(OP_FLUSH, 4'd0, 32'd0, 32'd0, KIND_KERNEL, CLASS_FREE));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_overlay_split();
    test_capacity();
    test_random();
    test_quiet_tail();
    drain_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && descs_expected.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: region_overlay_splitter_unit.f
src/ros_pkg.sv
src/ros_ram.sv
src/region_overlay_splitter_unit.sv
src/ros_checker.sv
tb/tb_top.sv
